FILE: src/cpc_pkg.sv
// Shared types and constants for the circle pixel counter.
// Controller states and the command/status bundles between controller and datapath.
package cpc_pkg;

   localparam int COUNT_BITS = 43;
   // Quadrant sum; the x4 scale is a 2-bit shift, so the sum is two bits narrower than the count.
   localparam int SUM_BITS   = COUNT_BITS - 2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;     // capture radius, clear x and the sum, set y to R
      logic square;   // form R*R
      logic step;     // one compare step of the column walk
      logic publish;  // move the finished count to the output register
   } cmd_type;

   typedef struct packed {
      logic walk_done; // current step is the last one of the walk
   } status_type;

endpackage

FILE: src/circle_pixel_counter_unit.sv
// Top level of the circle pixel counter: pixels touched by a circle of a given radius.
// Depends on cpc_pkg, cpc_ctrl and cpc_datapath.
//
//   channel | ports                              | direction
//   req     | req_valid, req_ready, req_radius    | in
//   rsp     | rsp_valid, rsp_ready, rsp_pixel_count | out
//
// Steps: one radius R is accepted, squared in the squarer step, then walked with one
//   compare step per column advance or height decrement, and published.
// The walk's single compare-and-update step per cycle sets the rate.
// Reset (synchronous) returns the controller to idle and drops rsp_valid.
// A finished count waits in the output register; the next radius is accepted meanwhile,
//   and only its publish waits for that transfer.
module circle_pixel_counter_unit import cpc_pkg::*; #(
   parameter int RADIUS_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [RADIUS_BITS-1:0] req_radius,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COUNT_BITS-1:0]  rsp_pixel_count
);

   cmd_type    cmd;
   status_type sts;

   cpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cpc_datapath #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_radius      (req_radius),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_pixel_count (rsp_pixel_count)
   );

endmodule

FILE: src/cpc_ctrl.sv
// Controller state machine for the circle pixel counter.
// Depends on cpc_pkg; drives cpc_datapath through cmd_type and owns the result valid.
module cpc_ctrl import cpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.load    = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (sts.walk_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.publish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_square: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SQUARE)
      else $error("accepted radius did not start the square step");

   a_publish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result published over an untaken result");

   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not shown");

   a_finish_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK && sts.walk_done |=> state_ff == ST_FINISH)
      else $error("walk end did not reach finish");

endmodule

FILE: src/cpc_datapath.sv
// Datapath of the circle pixel counter: squarer, incremental x*x / y*y walk, sum, result register.
// Depends on cpc_pkg; commanded by cpc_ctrl.
module cpc_datapath import cpc_pkg::*; #(
   parameter int RADIUS_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RADIUS_BITS-1:0] req_radius,
   input  cmd_type                cmd,
   output status_type             sts,
   output logic [COUNT_BITS-1:0]  rsp_pixel_count
);

   localparam int SQ_BITS = 2 * RADIUS_BITS;

   logic [RADIUS_BITS-1:0] r_ff, x_ff, y_ff;
   logic [SQ_BITS-1:0]     r2_ff, x2_ff, y2_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [SQ_BITS-1:0]     r_sq;
   logic [SQ_BITS:0]       dist2;
   logic                   hit, last_col, y_zero;

   assign r_sq     = SQ_BITS'(r_ff) * SQ_BITS'(r_ff);
   assign dist2    = {1'b0, x2_ff} + {1'b0, y2_ff};
   assign hit      = dist2 < {1'b0, r2_ff};
   assign last_col = (x_ff == r_ff);
   assign y_zero   = (y_ff == '0);

   // column closes on a hit; walk ends on the last column's hit or when y runs out
   assign sts.walk_done = hit ? last_col : y_zero;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff   <= req_radius;
         x_ff   <= '0;
         y_ff   <= req_radius;
         x2_ff  <= '0;
         sum_ff <= '0;
      end
      if (cmd.square) begin
         r2_ff <= r_sq;
         y2_ff <= r_sq;
      end
      if (cmd.step) begin
         if (hit) begin
            sum_ff <= sum_ff + SUM_BITS'(y_ff) + SUM_BITS'(1);
            x_ff   <= x_ff + RADIUS_BITS'(1);
            x2_ff  <= x2_ff + (SQ_BITS'(x_ff) << 1) + SQ_BITS'(1);
         end else if (!y_zero) begin
            y_ff  <= y_ff - RADIUS_BITS'(1);
            y2_ff <= y2_ff - (SQ_BITS'(y_ff) << 1) + SQ_BITS'(1);
         end
      end
      if (cmd.publish) count_ff <= {sum_ff, 2'b00};
   end

   assign rsp_pixel_count = count_ff;

   a_y_never_rises: assert property (@(posedge clock) disable iff (reset)
      cmd.step && !sts.walk_done |=> y_ff <= $past(y_ff))
      else $error("column height increased during walk");

   a_y2_tracks: assert property (@(posedge clock) disable iff (reset)
      cmd.step && !sts.walk_done |=> y2_ff == SQ_BITS'(y_ff) * SQ_BITS'(y_ff))
      else $error("y*y register out of step with y");

   a_x2_tracks: assert property (@(posedge clock) disable iff (reset)
      cmd.step && !sts.walk_done |=> x2_ff == SQ_BITS'(x_ff) * SQ_BITS'(x_ff))
      else $error("x*x register out of step with x");

endmodule
